>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int KEY_W           = 32;
   localparam int DATA_W          = 32;
   localparam int CAP_W           = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;
   localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

   // value of the top address bit that selects the capacity register
   localparam logic CSR_CAPACITY = 1'b0;

   typedef enum logic {
      CMD_GET,
      CMD_PUT
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic match;
      logic update;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// sequencer: capture, match, update, respond
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ctrl
   import lkv_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output logic              rsp_strobe,
   output ctrl_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// key compare row, recency ranks, value memory and result formatting
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_datapath
   import lkv_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   input  wire logic [CAP_W-1:0]         capacity,
   input  wire logic                     req_command,
   input  wire logic signed [KEY_W-1:0]  req_key,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_found,
   output logic signed [DATA_W-1:0]      rsp_read_value
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // operation registers
   cmd_code_type             op_cmd_ff;
   logic [KEY_W-1:0]         op_key_ff;
   logic [DATA_W-1:0]        op_value_ff;

   // entry state
   logic [KEY_W-1:0]         key_ff [ENTRIES];
   logic [DATA_W-1:0]        value_mem [ENTRIES];
   logic [ENTRIES-1:0]       valid_ff;
   logic [ENTRIES-1:0]       valid_in;
   logic [IDX_W-1:0]         rank_ff [ENTRIES];
   logic [IDX_W-1:0]         rank_in [ENTRIES];
   logic [CNT_W-1:0]         used_ff;
   logic [CNT_W-1:0]         used_in;

   // match stage results
   logic                     found_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic [IDX_W-1:0]         hit_rank_ff;
   logic [ENTRIES-1:0]       hit_vec_ff;
   logic [ENTRIES-1:0]       keep_ff;
   logic                     full_ff;
   logic [DATA_W-1:0]        rdata_ff;

   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         cap_eff;
   logic [CMP_W-1:0]         cap_m1;
   logic                     full;
   logic [ENTRIES-1:0]       match_vec;
   logic [ENTRIES-1:0]       keep_vec;
   logic [IDX_W-1:0]         hit_idx;
   logic [IDX_W-1:0]         hit_rank;

   logic [ENTRIES-1:0]       free_onehot;
   logic [IDX_W-1:0]         free_idx;
   logic [IDX_W-1:0]         wr_idx;
   logic                     insert;
   logic                     is_put;

   // effective capacity and full flag
   always_comb begin
      cap_ext = CMP_W'(capacity);
      cap_eff = cap_ext;
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
      cap_m1 = cap_eff - CMP_W'(1);
      full   = CMP_W'(used_ff) >= cap_eff;
   end

   // parallel compare
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (key_ff[i] == op_key_ff);
         keep_vec[i]  = valid_ff[i] && !(full && (CMP_W'(rank_ff[i]) >= cap_m1));
         if (match_vec[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
   end

   // lowest free slot after eviction
   always_comb begin
      free_onehot = ~keep_ff & (keep_ff + ENTRIES'(1));
      free_idx    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
      is_put = (op_cmd_ff == CMD_PUT);
      insert = is_put && !found_ff;
      wr_idx = found_ff ? hit_idx_ff : free_idx;
   end

   // rank, valid and fill update
   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.update) begin
         if (found_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_vec_ff[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
         end else if (insert) begin
            valid_in = keep_ff | free_onehot;
            for (int i = 0; i < ENTRIES; i++) begin
               if (free_onehot[i]) begin
                  rank_in[i] = '0;
               end else if (keep_ff[i]) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
            used_in = full_ff ? CNT_W'(cap_eff) : used_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_cmd_ff   <= cmd_code_type'(req_command);
         op_key_ff   <= req_key;
         op_value_ff <= req_value;
      end
      if (cmd.match) begin
         found_ff    <= |match_vec;
         hit_idx_ff  <= hit_idx;
         hit_rank_ff <= hit_rank;
         hit_vec_ff  <= match_vec;
         keep_ff     <= keep_vec;
         full_ff     <= full;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.update && insert && free_onehot[i]) begin
            key_ff[i] <= op_key_ff;
         end
      end
   end

   // value memory
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (is_put) begin
            value_mem[wr_idx] <= op_value_ff;
         end
         rdata_ff <= value_mem[hit_idx_ff];
      end
   end

   always_comb begin
      rsp_found = found_ff;
      if (op_cmd_ff == CMD_PUT) begin
         rsp_read_value = PUT_VALUE;
      end else if (found_ff) begin
         rsp_read_value = rdata_ff;
      end else begin
         rsp_read_value = MISS_VALUE;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
//
//   channel   ports                               transfer
//   request   start, busy, req_*                  start high while busy low
//   response  rsp_strobe, rsp_*                   one cycle, rsp_strobe high
//   csr       csr_psel/penable/pwrite/paddr/...   apb access phase, no waits
//
// a request runs through capture, key compare across all entries, rank and
// memory update with value read, then the response; the value memory is read
// in the update step, after the compare.
// reset clears valid bits, ranks and fill; capacity resets to 16.
// the response cannot be stalled; busy holds requests off.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_command,
   input  wire logic signed [KEY_W-1:0]      req_key,
   input  wire logic signed [DATA_W-1:0]     req_value,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic signed [DATA_W-1:0]          rsp_read_value,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]             csr_prdata,
   output logic                              csr_pready
);

   ctrl_cmd_type      cmd;
   logic [CAP_W-1:0]  capacity_ff;
   logic [CAP_W-1:0]  capacity_in;
   logic              csr_sel_cap;

   assign csr_pready  = 1'b1;
   assign csr_sel_cap = (csr_paddr[CSR_ADDR_W-1] == CSR_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_cap) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
      csr_prdata = '0;
      if (csr_sel_cap) begin
         csr_prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   lkv_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .capacity       (capacity_ff),
      .req_command    (req_command),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value)
   );

endmodule

`default_nettype wire
